@@ rtl/ffha_pkg.sv @@
// ---------------------------------------------------------------------------
// ffha_pkg: shared definitions for the first-fit hole allocator
// Field widths, operation and status codes, and the command and status
// bundles that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package ffha_pkg;

	// Fixed widths of the channel fields.
	localparam int OP_W     = 2;
	localparam int SIZE_W   = 16;
	localparam int IDX_W    = 4;
	localparam int STATUS_W = 2;

	// Default sizing of the hole table.
	localparam int HOLES_DEF     = 16;
	localparam int SIZE_BITS_DEF = 16;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC  = 2'd1;
	localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOFIT = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_ERROR = 2'd2;

	// Which result the datapath captures.
	typedef enum logic [2:0] {
		RES_LOAD,
		RES_HIT,
		RES_REPORT,
		RES_NOFIT,
		RES_ERR_ZERO,
		RES_ERR_IDX
	} res_kind_t;

	// Controller to datapath.
	typedef struct packed {
		logic      req_latch;
		logic      load_write;
		logic      hit_write;
		logic      report_read;
		logic      scan_start;
		logic      scan_run;
		logic      res_capture;
		res_kind_t res_kind;
		logic      out_load;
	} ffha_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            table_full;
		logic            table_empty;
		logic            idx_ok;
		logic            cmp_hit;
		logic            scan_miss;
		logic            out_free;
	} ffha_sts_t;

endpackage

@@ rtl/ffha_if.sv @@
// ---------------------------------------------------------------------------
// ffha_if: request and response channels of the hole allocator
// Valid/ready channels; a beat moves when valid and ready are both high.
// ---------------------------------------------------------------------------
interface ffha_req_if;
	logic                           valid;
	logic                           ready;
	logic [ffha_pkg::OP_W-1:0]      op;
	logic [ffha_pkg::SIZE_W-1:0]    size;
	logic [ffha_pkg::IDX_W-1:0]     query_index;

	modport source (output valid, output op, output size, output query_index, input ready);
	modport sink   (input valid, input op, input size, input query_index, output ready);
endinterface

interface ffha_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [ffha_pkg::STATUS_W-1:0]  status;
	logic [ffha_pkg::IDX_W-1:0]     hole_number;
	logic [ffha_pkg::SIZE_W-1:0]    original_size;
	logic [ffha_pkg::SIZE_W-1:0]    free_size;

	modport source (output valid, output status, output hole_number, output original_size,
		output free_size, input ready);
	modport sink   (input valid, input status, input hole_number, input original_size,
		input free_size, output ready);
endinterface

@@ rtl/ffha_ram.sv @@
// ---------------------------------------------------------------------------
// ffha_ram: simple dual-port RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module ffha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/ffha_ctrl.sv @@
// ---------------------------------------------------------------------------
// ffha_ctrl: sequencer of the hole allocator
// Decodes each request and steps the datapath through load, report or
// the first-fit scan, then hands the result to the output register.
// ---------------------------------------------------------------------------
module ffha_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ffha_pkg::ffha_sts_t sts,
	output ffha_pkg::ffha_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_RPT,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	// Command decode and next state.
	always_comb begin
		cmd = '0;
		cmd.res_kind = ffha_pkg::RES_ERR_ZERO;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.req_latch = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_DONE;
				unique case (sts.op)
					ffha_pkg::OP_LOAD: begin
						cmd.res_capture = 1'b1;
						if (sts.table_full) begin
							cmd.res_kind = ffha_pkg::RES_ERR_ZERO;
						end else begin
							cmd.load_write = 1'b1;
							cmd.res_kind = ffha_pkg::RES_LOAD;
						end
					end
					ffha_pkg::OP_ALLOC: begin
						if (sts.table_empty) begin
							cmd.res_capture = 1'b1;
							cmd.res_kind = ffha_pkg::RES_NOFIT;
						end else begin
							cmd.scan_start = 1'b1;
							state_d = S_SCAN;
						end
					end
					ffha_pkg::OP_REPORT: begin
						if (sts.idx_ok) begin
							cmd.report_read = 1'b1;
							state_d = S_RPT;
						end else begin
							cmd.res_capture = 1'b1;
							cmd.res_kind = ffha_pkg::RES_ERR_IDX;
						end
					end
					default: begin
						cmd.res_capture = 1'b1;
						cmd.res_kind = ffha_pkg::RES_ERR_ZERO;
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.cmp_hit) begin
					cmd.hit_write = 1'b1;
					cmd.res_capture = 1'b1;
					cmd.res_kind = ffha_pkg::RES_HIT;
					state_d = S_DONE;
				end else if (sts.scan_miss) begin
					cmd.res_capture = 1'b1;
					cmd.res_kind = ffha_pkg::RES_NOFIT;
					state_d = S_DONE;
				end
			end
			S_RPT: begin
				cmd.res_capture = 1'b1;
				cmd.res_kind = ffha_pkg::RES_REPORT;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A load write never happens on a full table.
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_write |-> !sts.table_full)
		else $error("load write issued on a full table");

	// The output register is only loaded when it can take a beat.
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded into a busy output register");

	// An accepted request is executed in the next cycle.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_EXEC))
		else $error("accepted request not executed");

endmodule

@@ rtl/ffha_dp.sv @@
// ---------------------------------------------------------------------------
// ffha_dp: datapath of the hole allocator
// Holds the request, the hole count, the hole table RAM, the scan
// counters, the result and the output register.
// ---------------------------------------------------------------------------
module ffha_dp #(
	parameter int HOLES     = ffha_pkg::HOLES_DEF,
	parameter int SIZE_BITS = ffha_pkg::SIZE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ffha_pkg::ffha_cmd_t               cmd,
	output ffha_pkg::ffha_sts_t               sts,
	input  logic [ffha_pkg::OP_W-1:0]         in_op,
	input  logic [ffha_pkg::SIZE_W-1:0]       in_size,
	input  logic [ffha_pkg::IDX_W-1:0]        in_query_index,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [ffha_pkg::STATUS_W-1:0]     out_status,
	output logic [ffha_pkg::IDX_W-1:0]        out_hole_number,
	output logic [ffha_pkg::SIZE_W-1:0]       out_original_size,
	output logic [ffha_pkg::SIZE_W-1:0]       out_free_size
);

	localparam int IW = (HOLES > 1) ? $clog2(HOLES) : 1;
	localparam int CW = $clog2(HOLES + 1);

	// Request registers.
	logic [ffha_pkg::OP_W-1:0]  op_q;
	logic [SIZE_BITS-1:0]       size_q;
	logic [ffha_pkg::IDX_W-1:0] qidx_q;

	// Table fill and scan state.
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_idx_q;
	logic          cmp_vld_q;
	logic [IW-1:0] cmp_idx_q;

	// Result and output registers.
	logic [ffha_pkg::STATUS_W-1:0] res_status_q;
	logic [ffha_pkg::IDX_W-1:0]    res_num_q;
	logic [SIZE_BITS-1:0]          res_orig_q;
	logic [SIZE_BITS-1:0]          res_free_q;
	logic                          out_valid_q;
	logic [ffha_pkg::STATUS_W-1:0] out_status_q;
	logic [ffha_pkg::IDX_W-1:0]    out_num_q;
	logic [ffha_pkg::SIZE_W-1:0]   out_orig_q;
	logic [ffha_pkg::SIZE_W-1:0]   out_free_q;

	// RAM ports.
	logic                   ram_we;
	logic [IW-1:0]          ram_waddr;
	logic [2*SIZE_BITS-1:0] ram_wdata;
	logic [IW-1:0]          ram_raddr;
	logic [2*SIZE_BITS-1:0] ram_rdata;

	// Width adapters.
	logic [47:0]          size_wide;
	logic [SIZE_BITS-1:0] size_in;
	logic [31:0]          qidx_wide;
	logic [IW-1:0]        qaddr;
	logic [31:0]          count_wide;
	logic [31:0]          cmp_idx_wide;
	logic [47:0]          orig_wide;
	logic [47:0]          free_wide;

	// Table read data and compare.
	logic [SIZE_BITS-1:0] rd_orig;
	logic [SIZE_BITS-1:0] rd_free;
	logic [SIZE_BITS-1:0] free_after;
	logic                 fits;
	logic                 cmp_hit;
	logic                 scan_issue;

	assign size_wide    = 48'(in_size);
	assign size_in      = size_wide[SIZE_BITS-1:0];
	assign qidx_wide    = 32'(qidx_q);
	assign qaddr        = qidx_wide[IW-1:0];
	assign count_wide   = 32'(count_q);
	assign cmp_idx_wide = 32'(cmp_idx_q);

	assign rd_orig    = ram_rdata[2*SIZE_BITS-1:SIZE_BITS];
	assign rd_free    = ram_rdata[SIZE_BITS-1:0];
	assign free_after = rd_free - size_q;
	assign fits       = (size_q <= rd_free);
	assign cmp_hit    = cmp_vld_q && fits;
	assign scan_issue = cmd.scan_run && !cmp_hit && (rd_idx_q < count_q);

	// Status toward the controller.
	always_comb begin
		sts.op          = op_q;
		sts.table_full  = (count_q == CW'(HOLES));
		sts.table_empty = (count_q == '0);
		sts.idx_ok      = (qidx_wide < count_wide);
		sts.cmp_hit     = cmp_hit;
		sts.scan_miss   = cmp_vld_q && !fits && (CW'(cmp_idx_q) == (count_q - CW'(1)));
		sts.out_free    = !out_valid_q || out_ready;
	end

	// Table write port: a new hole, or the shrunk hole of an allocation.
	always_comb begin
		ram_we    = cmd.load_write || cmd.hit_write;
		ram_waddr = cmd.hit_write ? cmp_idx_q : count_q[IW-1:0];
		ram_wdata = cmd.hit_write ? {rd_orig, free_after} : {size_q, size_q};
	end

	// Table read port: the report index, or the next hole of the scan.
	always_comb begin
		ram_raddr = '0;
		if (cmd.report_read) begin
			ram_raddr = qaddr;
		end else if (scan_issue) begin
			ram_raddr = rd_idx_q[IW-1:0];
		end
	end

	ffha_ram #(
		.WIDTH (2 * SIZE_BITS),
		.DEPTH (HOLES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.req_latch) begin
			op_q   <= in_op;
			size_q <= size_in;
			qidx_q <= in_query_index;
		end
	end

	// Hole count and scan pipeline: one read issued per cycle, compared in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rd_idx_q  <= '0;
			cmp_vld_q <= 1'b0;
			cmp_idx_q <= '0;
		end else begin
			if (cmd.load_write) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.scan_start) begin
				rd_idx_q  <= '0;
				cmp_vld_q <= 1'b0;
			end else if (cmd.scan_run) begin
				cmp_vld_q <= scan_issue;
				if (scan_issue) begin
					rd_idx_q  <= rd_idx_q + CW'(1);
					cmp_idx_q <= rd_idx_q[IW-1:0];
				end
			end
		end
	end

	// Result capture.
	always_ff @(posedge clk) begin
		if (cmd.res_capture) begin
			unique case (cmd.res_kind)
				ffha_pkg::RES_LOAD: begin
					res_status_q <= ffha_pkg::STAT_DONE;
					res_num_q    <= count_wide[ffha_pkg::IDX_W-1:0];
					res_orig_q   <= size_q;
					res_free_q   <= size_q;
				end
				ffha_pkg::RES_HIT: begin
					res_status_q <= ffha_pkg::STAT_DONE;
					res_num_q    <= cmp_idx_wide[ffha_pkg::IDX_W-1:0];
					res_orig_q   <= rd_orig;
					res_free_q   <= free_after;
				end
				ffha_pkg::RES_REPORT: begin
					res_status_q <= ffha_pkg::STAT_DONE;
					res_num_q    <= qidx_q;
					res_orig_q   <= rd_orig;
					res_free_q   <= rd_free;
				end
				ffha_pkg::RES_NOFIT: begin
					res_status_q <= ffha_pkg::STAT_NOFIT;
					res_num_q    <= '0;
					res_orig_q   <= '0;
					res_free_q   <= '0;
				end
				ffha_pkg::RES_ERR_IDX: begin
					res_status_q <= ffha_pkg::STAT_ERROR;
					res_num_q    <= qidx_q;
					res_orig_q   <= '0;
					res_free_q   <= '0;
				end
				default: begin
					res_status_q <= ffha_pkg::STAT_ERROR;
					res_num_q    <= '0;
					res_orig_q   <= '0;
					res_free_q   <= '0;
				end
			endcase
		end
	end

	assign orig_wide = 48'(res_orig_q);
	assign free_wide = 48'(res_free_q);

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_num_q    <= res_num_q;
			out_orig_q   <= orig_wide[ffha_pkg::SIZE_W-1:0];
			out_free_q   <= free_wide[ffha_pkg::SIZE_W-1:0];
		end
	end

	assign out_valid         = out_valid_q;
	assign out_status        = out_status_q;
	assign out_hole_number   = out_num_q;
	assign out_original_size = out_orig_q;
	assign out_free_size     = out_free_q;

	// The hole count never passes the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_wide <= 32'(HOLES))
		else $error("hole count beyond table depth");

	// The hole count grows by at most one per cycle and never shrinks.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + CW'(1)))
		else $error("hole count changed by more than one");

	// A compared hole always lies inside the loaded part of the table.
	a_cmp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_run && cmp_vld_q) |-> (CW'(cmp_idx_q) < count_q))
		else $error("scan compared an unloaded hole");

endmodule

@@ rtl/first_fit_hole_allocator_core.sv @@
// ---------------------------------------------------------------------------
// first_fit_hole_allocator_core: first-fit hole table
// A request beat on req carries op, size and query_index. Load appends a
// hole, allocate takes the request from the lowest-numbered hole that has
// room, report returns one hole. Every request yields one response beat
// on rsp with status, hole_number, original_size and free_size.
// Requests are taken one at a time: req.ready is high only while the block
// is idle. A load, an error or an empty-table allocation goes straight
// from the request registers to the result register; a report first reads
// the table entry; an allocation scans the loaded holes from hole 0 and
// stops at the first that fits or after the last one. The scan reads one
// table entry per cycle through the RAM read port. The next request is
// accepted after the response enters the output register, with one request
// at a time in flight. If rsp stalls, the response waits in the output
// register and a finished result waits in the block, which then takes no
// new request. Reset empties the table by clearing the hole count; the
// table RAM itself is not cleared.
// ---------------------------------------------------------------------------
module first_fit_hole_allocator_core #(
	parameter int HOLES     = ffha_pkg::HOLES_DEF,
	parameter int SIZE_BITS = ffha_pkg::SIZE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ffha_req_if.sink    req,
	ffha_rsp_if.source  rsp
);

	ffha_pkg::ffha_cmd_t cmd;
	ffha_pkg::ffha_sts_t sts;
	logic                req_ready;

	assign req.ready = req_ready;

	// Sequencer.
	ffha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Table, scan and output register.
	ffha_dp #(
		.HOLES     (HOLES),
		.SIZE_BITS (SIZE_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.in_op             (req.op),
		.in_size           (req.size),
		.in_query_index    (req.query_index),
		.out_ready         (rsp.ready),
		.out_valid         (rsp.valid),
		.out_status        (rsp.status),
		.out_hole_number   (rsp.hole_number),
		.out_original_size (rsp.original_size),
		.out_free_size     (rsp.free_size)
	);

endmodule
